FILE: hdl/bdss_pkg.sv
package bdss_pkg;

   localparam int CAPACITY = 64;
   localparam int DATE_W = 27;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_W = 7;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      logic              do_insert;
      logic              do_remove;
      logic [DATE_W-1:0] key;
   } cell_ctrl_type;

endpackage

FILE: hdl/bdss_cell.sv
module bdss_cell (
   input  logic                        clock,
   input  bdss_pkg::cell_ctrl_type     ctrl,
   input  logic                        valid,
   input  logic                        below_prev,
   input  logic [bdss_pkg::DATE_W-1:0] prev_entry,
   input  logic [bdss_pkg::DATE_W-1:0] next_entry,
   output logic [bdss_pkg::DATE_W-1:0] entry,
   output logic                        below,
   output logic                        hit
);

   logic [bdss_pkg::DATE_W-1:0] entry_ff;
   logic [bdss_pkg::DATE_W-1:0] entry_in;

   assign below = valid && (entry_ff < ctrl.key);
   assign hit   = valid && (entry_ff == ctrl.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert && !below) begin
         entry_in = below_prev ? ctrl.key : prev_entry;
      end else if (ctrl.do_remove && !below) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: hdl/blackout_date_sorted_set.sv
// Sorted set of packed YYYYMMDD dates held in a row of compare-and-shift cells, one
// date per cell, in ascending order. Every cell compares its date with the request key
// in the cycle of the transfer, so add, remove, query and clear act on all cells at once and
// a new request is taken every cycle; the result appears on the next cycle and is held in
// an output register, so throughput drops only while rsp_tready is low. No clearing pass
// follows reset. An add of a new date into a full set leaves it unchanged and sets
// add_dropped.
module blackout_date_sorted_set (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] mode, [28:2] date_key, [31:29] zero
   input  logic [bdss_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] was_present, [7:1] entry_count, [8] add_dropped, [15:9] zero
   output logic [bdss_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CAP = bdss_pkg::CAPACITY;
   localparam int DW = bdss_pkg::DATE_W;
   localparam int CW = bdss_pkg::CNT_W;
   localparam int EW = bdss_pkg::ENTRY_COUNT_W;

   logic                    req_fire;
   bdss_pkg::mode_type      mode;
   logic [DW-1:0]           key;
   bdss_pkg::cell_ctrl_type ctrl;

   logic [CAP-1:0]          valid;
   logic [CAP-1:0]          below;
   logic [CAP-1:0]          hit;
   logic [DW-1:0]           entry [CAP];
   logic                    present;
   logic                    full;
   logic                    dropped;

   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    present_ff;
   logic                    dropped_ff;
   logic [CW+EW-1:0]        count_wide;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign mode       = bdss_pkg::mode_type'(req_tdata[1:0]);
   assign key        = req_tdata[DW+1:2];

   assign present = |hit;
   assign full    = (count_ff >= CW'(CAP));
   assign dropped = (mode == bdss_pkg::MODE_ADD) && !present && full;

   always_comb begin
      ctrl.key       = key;
      ctrl.do_insert = req_fire && (mode == bdss_pkg::MODE_ADD) && !present && !full;
      ctrl.do_remove = req_fire && (mode == bdss_pkg::MODE_REMOVE) && present;
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic          below_prev;
      logic [DW-1:0] prev_entry;
      logic [DW-1:0] next_entry;

      assign valid[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign below_prev = 1'b1;
         assign prev_entry = key;
      end else begin : g_mid
         assign below_prev = below[i-1];
         assign prev_entry = entry[i-1];
      end

      if (i == CAP - 1) begin : g_last
         assign next_entry = key;
      end else begin : g_inner
         assign next_entry = entry[i+1];
      end

      bdss_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .valid      (valid[i]),
         .below_prev (below_prev),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entry[i]),
         .below      (below[i]),
         .hit        (hit[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         case (mode)
            bdss_pkg::MODE_ADD: begin
               if (ctrl.do_insert) count_in = count_ff + CW'(1);
            end
            bdss_pkg::MODE_REMOVE: begin
               if (ctrl.do_remove) count_in = count_ff - CW'(1);
            end
            bdss_pkg::MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         present_ff <= present;
         dropped_ff <= dropped;
      end
   end

   assign count_wide = {{EW{1'b0}}, count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bdss_pkg::RSP_TDATA_W - EW - 2){1'b0}}, dropped_ff,
                        count_wide[EW-1:0], present_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAP))
      else $error("stored count above capacity");

   a_drop_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[EW+1] && rsp_tdata[0]))
      else $error("dropped add reported a present date");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (mode == bdss_pkg::MODE_CLEAR) |=> count_ff == '0)
      else $error("clear left entries");

   a_query_keeps: assert property (@(posedge clock) disable iff (reset)
      req_fire && (mode == bdss_pkg::MODE_QUERY) |=> $stable(count_ff))
      else $error("query changed the count");
`endif

endmodule

FILE: tb/date_set_checker.sv
module date_set_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // [1:0] mode, [28:2] date_key, [31:29] zero
   input  logic [bdss_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] was_present, [7:1] entry_count, [8] add_dropped, [15:9] zero
   input  logic [bdss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               error_count,
   output int                               open_count
);

   typedef struct packed {
      logic                               add_dropped;
      logic [bdss_pkg::ENTRY_COUNT_W-1:0] entry_count;
      logic                               was_present;
   } date_result_type;

   logic [bdss_pkg::DATE_W-1:0] set_dates [bdss_pkg::CAPACITY];
   int                          set_size;
   date_result_type             expected_results [$];
   int                          mismatches;

   function automatic date_result_type apply_date_op(bdss_pkg::mode_type op,
                                                     logic [bdss_pkg::DATE_W-1:0] key);
      int              pos;
      logic            hit;
      date_result_type res;
      pos = 0;
      while (pos < set_size && set_dates[pos] < key)
         pos++;
      hit = (pos < set_size) && (set_dates[pos] == key);
      res.was_present = hit;
      res.add_dropped = 1'b0;
      case (op)
         bdss_pkg::MODE_ADD: begin
            if (!hit) begin
               if (set_size >= bdss_pkg::CAPACITY) begin
                  res.add_dropped = 1'b1;
               end else begin
                  for (int i = set_size; i > pos; i--)
                     set_dates[i] = set_dates[i-1];
                  set_dates[pos] = key;
                  set_size++;
               end
            end
         end
         bdss_pkg::MODE_REMOVE: begin
            if (hit) begin
               for (int i = pos; i + 1 < set_size; i++)
                  set_dates[i] = set_dates[i+1];
               set_size--;
            end
         end
         bdss_pkg::MODE_CLEAR: begin
            set_size = 0;
         end
         default: ;
      endcase
      res.entry_count = set_size[bdss_pkg::ENTRY_COUNT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      date_result_type got;
      date_result_type want;
      if (reset) begin
         set_size = 0;
         expected_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = date_result_type'(rsp_tdata[8:0]);
            if (expected_results.size() == 0) begin
               $error("rsp_tdata: no result expected, got %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.was_present !== want.was_present) begin
                  $error("was_present: expected %0d, got %0d",
                         want.was_present, got.was_present);
                  mismatches++;
               end
               if (got.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, got.entry_count);
                  mismatches++;
               end
               if (got.add_dropped !== want.add_dropped) begin
                  $error("add_dropped: expected %0d, got %0d",
                         want.add_dropped, got.add_dropped);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(
               apply_date_op(bdss_pkg::mode_type'(req_tdata[1:0]),
                             req_tdata[bdss_pkg::DATE_W+1:2]));
      end
      error_count <= mismatches;
      open_count  <= expected_results.size();
   end

endmodule

FILE: tb/blackout_date_sorted_set_test.sv
module blackout_date_sorted_set_test;

   localparam int DW           = bdss_pkg::DATE_W;
   localparam int RANDOM_ITEMS = 1500;
   localparam int POOL_SIZE    = 96;
   localparam int HOLD_CYCLES  = 200;
   localparam logic [DW-1:0] LAST_DATE = 27'd99991231;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [bdss_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [bdss_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   int                               check_errors;
   int                               open_count;
   int                               sent_count;
   logic [DW-1:0]                    key_pool [POOL_SIZE];

   blackout_date_sorted_set i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   date_set_checker i_date_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (check_errors),
      .open_count  (open_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_req(input bdss_pkg::mode_type op, input logic [DW-1:0] key,
                           input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, key, op};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent_count++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic refill_pool();
      logic [DW-1:0] base;
      base = DW'($urandom_range(0, 99991231 - POOL_SIZE));
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = (i < POOL_SIZE / 2) ? DW'(base + i)
                                           : DW'($urandom_range(0, 99991231));
   endtask

   // receiver: random stalls, quiet stretches, and long hold-offs to back up the block
   initial begin
      int hold_mark;
      int quiet;
      int r;
      hold_mark = 300;
      quiet = 0;
      rsp_tready <= 1'b0;
      forever begin
         if (sent_count >= hold_mark) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_mark += 500;
         end else if (quiet > 0) begin
            rsp_tready <= 1'b1;
            quiet--;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               quiet = $urandom_range(30, 120);
            end else if (r < 75) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else if (r < 95) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end
         end
      end
   end

   // sender: directed items, then random sequences, then verdict
   initial begin
      int                 target;
      int                 kind;
      int                 seq_len;
      int                 r;
      bit                 burst;
      bdss_pkg::mode_type op;
      logic [DW-1:0]      key;
      sent_count = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_req(bdss_pkg::MODE_CLEAR,  27'd0,        pick_gap(0));
      send_req(bdss_pkg::MODE_QUERY,  27'd0,        pick_gap(0));
      send_req(bdss_pkg::MODE_REMOVE, 27'd20240101, pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    27'd0,        pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    LAST_DATE,    pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    27'h7FFFFFF,  pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    27'd20240101, pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    27'd20240101, pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    27'd19991231, pick_gap(0));
      send_req(bdss_pkg::MODE_ADD,    27'd20240229, 0);
      send_req(bdss_pkg::MODE_QUERY,  27'd20240101, 0);
      send_req(bdss_pkg::MODE_QUERY,  27'd20240102, 0);
      send_req(bdss_pkg::MODE_QUERY,  27'h7FFFFFF,  pick_gap(0));
      send_req(bdss_pkg::MODE_REMOVE, 27'd20240101, pick_gap(0));
      send_req(bdss_pkg::MODE_REMOVE, 27'd20240101, pick_gap(0));
      send_req(bdss_pkg::MODE_REMOVE, 27'd0,        pick_gap(0));
      send_req(bdss_pkg::MODE_REMOVE, 27'h7FFFFFF,  pick_gap(0));
      send_req(bdss_pkg::MODE_CLEAR,  27'd0,        pick_gap(0));
      send_req(bdss_pkg::MODE_QUERY,  LAST_DATE,    pick_gap(0));
      send_req(bdss_pkg::MODE_CLEAR,  LAST_DATE,    pick_gap(0));

      refill_pool();
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         kind    = $urandom_range(0, 9);
         burst   = ($urandom_range(0, 3) == 0);
         seq_len = $urandom_range(40, 150);
         if ($urandom_range(0, 3) == 0)
            refill_pool();
         for (int n = 0; n < seq_len && sent_count < target; n++) begin
            r = $urandom_range(0, 99);
            if (kind <= 3)                     // fill toward capacity
               op = (r < 75) ? bdss_pkg::MODE_ADD : (r < 89) ? bdss_pkg::MODE_QUERY :
                    (r < 99) ? bdss_pkg::MODE_REMOVE : bdss_pkg::MODE_CLEAR;
            else if (kind <= 5)                // drain
               op = (r < 60) ? bdss_pkg::MODE_REMOVE : (r < 78) ? bdss_pkg::MODE_QUERY :
                    (r < 98) ? bdss_pkg::MODE_ADD : bdss_pkg::MODE_CLEAR;
            else if (kind <= 7)                // mixed
               op = (r < 33) ? bdss_pkg::MODE_ADD : (r < 64) ? bdss_pkg::MODE_REMOVE :
                    (r < 96) ? bdss_pkg::MODE_QUERY : bdss_pkg::MODE_CLEAR;
            else
               op = bdss_pkg::mode_type'($urandom_range(0, 3));
            if (kind >= 8)
               key = DW'(($urandom_range(0, 3) == 0) ? $urandom
                                                    : $urandom_range(0, 99991231));
            else if ($urandom_range(0, 9) < 8)
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               key = DW'($urandom_range(0, 99991231));
            send_req(op, key, pick_gap(burst));
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (open_count != 0)
         $error("%0d results never arrived", open_count);
      if (check_errors == 0 && open_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
